// ===== hw/rtl/iwss_pkg.sv =====
// Package for the interval window score sum core: sizes, codes and types.
// Used by iwss_accum and interval_window_score_sum_core.
// No dependencies.
package iwss_pkg;

   // Interval table size and the widths that follow from it.
   localparam int MAX_INTERVALS = 1024;
   localparam int ADDR_W        = $clog2(MAX_INTERVALS);
   localparam int CNT_W         = ADDR_W + 1;

   // Field widths.
   localparam int POS_W    = 31;
   localparam int SCORE_W  = 32;
   localparam int HALF_W   = 10;
   localparam int SUM_W    = 43;
   localparam int ACTION_W = 2;

   // Window bounds are signed and one bit wider than a position plus sign.
   localparam int BOUND_W = POS_W + 2;

   // Clipped overlap is at most 2 * 1023 + 1 bases.
   localparam int LEN_W  = HALF_W + 1;
   localparam int PROD_W = LEN_W + 1 + SCORE_W;
   localparam int ACC_W  = PROD_W + ADDR_W;

   // Stream word widths.
   localparam int REQ_DATA_W = 128;
   localparam int RSP_DATA_W = 48;

   localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(50);

   // One table entry as it sits in memory.
   localparam int ENTRY_W = SCORE_W + 2 * POS_W;

   // Item kinds carried on the request tuser.
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } state_type;

   // One clipped interval handed to the accumulate pipeline.
   typedef struct packed {
      logic                        valid;
      logic signed [BOUND_W-1:0]   first;
      logic signed [BOUND_W-1:0]   last;
      logic signed [SCORE_W-1:0]   score;
   } clip_type;

   // Control from the walker to the accumulate pipeline.
   typedef struct packed {
      logic clear;
   } acc_ctrl_type;

   // Status back from the accumulate pipeline.
   typedef struct packed {
      logic                      busy;
      logic signed [SUM_W-1:0]   sum;
   } acc_stat_type;

endpackage

// ===== hw/rtl/interval_window_score_sum_core.sv =====
// Top level of the interval window score sum core: table memory and query walker.
// Depends on iwss_pkg and iwss_accum.
//
// The core keeps up to 1024 scored intervals in one synchronous memory.
// Clear and append words are taken while the core is idle and give no response.
// A query word walks the table from entry 0, one memory read per cycle, until
// it reaches the entry whose end covers the window end or runs off the table;
// it then drains a short multiply and accumulate pipeline before the sum is emitted.
// No word is taken while a query is being walked; a finished response waits in an
// output register while new words are accepted. The window half width register may
// only be written while the core is idle.
module interval_window_score_sum_core (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: interval_start [30:0], interval_end [61:31], interval_score [93:62],
   //        query_position [124:94], zero fill [127:125]
   input  logic [iwss_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: action [1:0]
   input  logic [iwss_pkg::ACTION_W-1:0]     req_tuser,
   // Response stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: window_sum [42:0], zero fill [47:43]
   output logic [iwss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: status [0]
   output logic [0:0]                        rsp_tuser,
   // Window half width register.
   input  logic                              csr_we,
   input  logic [iwss_pkg::HALF_W-1:0]       csr_wdata
);
   import iwss_pkg::*;

   // Request fields.
   logic [POS_W-1:0]          f_start;
   logic [POS_W-1:0]          f_end;
   logic [SCORE_W-1:0]        f_score;
   logic [POS_W-1:0]          f_pos;

   // Interval table: {score, end, start}.
   logic [ENTRY_W-1:0]        table_mem [MAX_INTERVALS];
   logic [ENTRY_W-1:0]        rd_data_ff;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [HALF_W-1:0]         half_ff, half_in;
   logic signed [BOUND_W-1:0] lo_ff, lo_in;
   logic signed [BOUND_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0]          num_ff, num_in;
   logic [CNT_W-1:0]          addr_ff, addr_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic                      rd_last_ff, rd_last_in;
   logic                      found_ff, found_in;
   logic                      done_ff, done_in;
   logic                      off_ff, off_in;
   clip_type                  clip_ff, clip_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]          rsp_sum_ff, rsp_sum_in;
   logic                      rsp_off_ff, rsp_off_in;

   logic                      accept;
   logic                      query_start;
   logic                      do_append;
   logic                      issue;
   logic                      walk_end;
   logic                      emit;
   acc_ctrl_type              acc_ctrl;
   acc_stat_type              acc_stat;

   assign f_start = req_tdata[POS_W-1:0];
   assign f_end   = req_tdata[2*POS_W-1:POS_W];
   assign f_score = req_tdata[2*POS_W+SCORE_W-1:2*POS_W];
   assign f_pos   = req_tdata[3*POS_W+SCORE_W-1:2*POS_W+SCORE_W];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_start) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      walk_end   = 1'b0;
      emit       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_WALK: begin
            issue    = !done_ff && (addr_ff < num_ff);
            walk_end = done_ff && !clip_ff.valid && !acc_stat.busy;
         end
         ST_EMIT: begin
            emit = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign accept      = req_tvalid && req_tready;
   assign query_start = accept && (req_tuser == ACT_QUERY);
   assign do_append   = accept && (req_tuser == ACT_APPEND) && (count_ff < CNT_W'(MAX_INTERVALS));
   assign acc_ctrl.clear = query_start;

   // Table count and the half width register.
   always_comb begin
      count_in = count_ff;
      if (accept && (req_tuser == ACT_CLEAR)) begin
         count_in = '0;
      end else if (do_append) begin
         count_in = count_ff + CNT_W'(1);
      end
      half_in = csr_we ? csr_wdata : half_ff;
   end

   // Query setup and read issue.
   always_comb begin
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      num_in      = num_ff;
      addr_in     = addr_ff;
      rd_valid_in = issue;
      rd_last_in  = issue && (addr_ff == num_ff - CNT_W'(1));
      if (query_start) begin
         lo_in   = $signed({2'b00, f_pos}) - $signed(BOUND_W'(half_ff));
         hi_in   = $signed({2'b00, f_pos}) + $signed(BOUND_W'(half_ff));
         num_in  = count_ff;
         addr_in = '0;
      end else if (issue) begin
         addr_in = addr_ff + CNT_W'(1);
      end
   end

   // Walk step on the word read last cycle: find the first entry, clip, stop.
   always_comb begin
      logic signed [BOUND_W-1:0] e_first;
      logic signed [BOUND_W-1:0] e_last;
      logic                      below;
      logic                      reach;
      logic                      take;

      e_first = $signed({2'b00, rd_data_ff[POS_W-1:0]});
      e_last  = $signed({2'b00, rd_data_ff[2*POS_W-1:POS_W]});
      below   = e_last < lo_ff;
      reach   = e_last >= hi_ff;
      take    = rd_valid_ff && !done_ff && (found_ff || !below);

      found_in = found_ff;
      done_in  = done_ff;
      off_in   = off_ff;

      clip_in.valid = take;
      clip_in.first = (e_first < lo_ff) ? lo_ff : e_first;
      clip_in.last  = reach ? hi_ff : e_last;
      clip_in.score = $signed(rd_data_ff[ENTRY_W-1:2*POS_W]);

      if (query_start) begin
         // An empty table ends the walk at once.
         found_in = 1'b0;
         done_in  = (count_ff == '0);
         off_in   = (count_ff == '0);
      end else if (rd_valid_ff && !done_ff) begin
         if (take) begin
            found_in = 1'b1;
         end
         if (take && reach) begin
            done_in = 1'b1;
         end else if (rd_last_ff) begin
            done_in = 1'b1;
            off_in  = 1'b1;
         end
      end
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_off_in   = rsp_off_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = acc_stat.sum;
         rsp_off_in   = off_ff;
      end
   end

   // Table memory: append writes, one registered read per cycle.
   always_ff @(posedge clock) begin
      if (do_append) begin
         table_mem[count_ff[ADDR_W-1:0]] <= {f_score, f_end, f_start};
      end
      rd_data_ff <= table_mem[addr_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         half_ff       <= HALF_RESET;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         done_ff       <= 1'b1;
         off_ff        <= 1'b0;
         clip_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         half_ff       <= half_in;
         rd_valid_ff   <= rd_valid_in;
         found_ff      <= found_in;
         done_ff       <= done_in;
         off_ff        <= off_in;
         clip_ff.valid <= clip_in.valid;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      num_ff        <= num_in;
      addr_ff       <= addr_in;
      rd_last_ff    <= rd_last_in;
      clip_ff.first <= clip_in.first;
      clip_ff.last  <= clip_in.last;
      clip_ff.score <= clip_in.score;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_off_ff    <= rsp_off_in;
   end

   iwss_accum u_accum (
      .clock (clock),
      .reset (reset),
      .ctrl  (acc_ctrl),
      .clip  (clip_ff),
      .stat  (acc_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SUM_W)'(0), rsp_sum_ff};
   assign rsp_tuser  = rsp_off_ff;

endmodule

// ===== hw/rtl/iwss_accum.sv =====
// Accumulate pipeline: overlap length, product with score, running sum, saturation.
// Depends on iwss_pkg.
module iwss_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  iwss_pkg::acc_ctrl_type ctrl,
   input  iwss_pkg::clip_type    clip,
   output iwss_pkg::acc_stat_type stat
);
   import iwss_pkg::*;

   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'({1'b0, {(SUM_W-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

   logic                       len_valid_ff, len_valid_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic signed [SCORE_W-1:0]  score_ff;
   logic                       prod_valid_ff, prod_valid_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [BOUND_W-1:0]  diff;

   // Stage one: clipped length; an empty or inverted overlap adds nothing.
   always_comb begin
      diff         = clip.last - clip.first;
      len_valid_in = clip.valid && !diff[BOUND_W-1];
      len_in       = diff[LEN_W-1:0] + LEN_W'(1);
   end

   // Stage two: length times score.
   always_comb begin
      prod_valid_in = len_valid_ff;
      prod_in       = $signed({1'b0, len_ff}) * score_ff;
   end

   // Stage three: running sum, cleared at the start of each query.
   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         len_valid_ff  <= len_valid_in;
         prod_valid_ff <= prod_valid_in;
      end
      len_ff   <= len_in;
      score_ff <= clip.score;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

   // Status: pipeline occupancy and the saturated sum.
   always_comb begin
      stat.busy = len_valid_ff || prod_valid_ff;
      if (acc_ff > SAT_MAX) begin
         stat.sum = SAT_MAX[SUM_W-1:0];
      end else if (acc_ff < SAT_MIN) begin
         stat.sum = SAT_MIN[SUM_W-1:0];
      end else begin
         stat.sum = acc_ff[SUM_W-1:0];
      end
   end

endmodule
